/* src/lkr_pkg.sv */
package lkr_pkg;

   localparam int FRAME_COUNT = 64;
   localparam int K_MAX       = 4;
   localparam int STAMP_WIDTH = 32;

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int COUNT_W = $clog2(FRAME_COUNT + 1);
   localparam int KIDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int REF_W   = $clog2(K_MAX + 1);
   localparam int HIST_W  = STAMP_WIDTH * K_MAX;
   // per-frame entry: tracked, evictable, reference count
   localparam int META_W  = 2 + REF_W;

   typedef enum logic [1:0] {
      ACT_ACCESS = 2'd0,
      ACT_SET    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_EVICT  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_RANGE         = 3'd1,
      ST_NOT_TRACKED   = 3'd2,
      ST_NOT_EVICTABLE = 3'd3,
      ST_NONE          = 3'd4
   } status_type;

   localparam logic [6:0] CSR_FRAMES = 7'd0;
   localparam logic [6:0] CSR_DEPTH  = 7'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_OP,
      S_CLR_WAIT,
      S_CLR,
      S_SCAN,
      S_VREAD,
      S_VWRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic             tracked;
      logic             evictable;
      logic [REF_W-1:0] refs;
   } meta_type;

endpackage

/* src/lkr_ram.sv */
module lkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/lru_k_frame_replacer.sv */
// LRU-K frame replacer. Per-frame marks and the last K access stamps sit in two
// single-port-write, registered-read RAMs. Access, set and remove take a read, a
// modify and a write. Evict streams every frame through the RAMs one per cycle,
// favours frames seen fewer than K times, then the oldest stamp, and then
// clears the victim. The next req is taken in the cycle after the rsp beat.
// After reset the meta RAM is swept clear, while req_stall is high. One item
// is in work at a time; rsp is held in a register and req is stalled until it
// is taken.
module lru_k_frame_replacer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [5:0]                   req_frame,
   input  logic                         req_evictable_flag,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [5:0]                   rsp_evicted_frame,
   output logic [6:0]                   rsp_evictable_count,
   input  logic                         csr_write,
   input  logic [6:0]                   csr_index,
   input  logic [6:0]                   csr_data
);
   import lkr_pkg::*;

   state_type state_ff, state_in;

   logic [6:0] frames_ff, frames_in;
   logic [2:0] depth_ff, depth_in;

   logic [1:0]         act_ff, act_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               flag_ff, flag_in;

   logic [STAMP_WIDTH-1:0] stamp_ff, stamp_in;
   logic [COUNT_W-1:0]     total_ff, total_in;

   logic [FRAME_W:0]       scan_ff, scan_in;     // read address counter
   logic                   sv_ff, sv_in;         // data for scan_ff-1 is on the RAM outputs
   logic [FRAME_W-1:0]     sidx_ff, sidx_in;
   logic                   best_ok_ff, best_ok_in;
   logic                   best_young_ff, best_young_in;
   logic [FRAME_W-1:0]     best_ff, best_in;
   logic [STAMP_WIDTH-1:0] best_stamp_ff, best_stamp_in;

   logic [2:0]         st_ff, st_in;
   logic [FRAME_W-1:0] vic_ff, vic_in;
   logic               rv_ff, rv_in;

   logic               m_we, h_we;
   logic [FRAME_W-1:0] m_waddr, m_raddr, h_raddr;
   meta_type           m_wdata, m_rdata;
   logic [HIST_W-1:0]  h_wdata, h_rdata;

   lkr_ram #(.WIDTH(META_W), .DEPTH(FRAME_COUNT)) u_meta (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rdata));

   lkr_ram #(.WIDTH(HIST_W), .DEPTH(FRAME_COUNT)) u_hist (
      .clock(clock), .wr_en(h_we), .wr_addr(frame_ff), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata));

   // effective limits
   logic [6:0]       limit;
   logic [REF_W-1:0] k_eff;
   logic [KIDX_W-1:0] k_idx;
   always_comb begin
      limit = (frames_ff > 7'(FRAME_COUNT)) ? 7'(FRAME_COUNT) : frames_ff;
      if (depth_ff == 3'd0) begin
         k_eff = REF_W'(1);
      end else if ({1'b0, depth_ff} > 4'(K_MAX)) begin
         k_eff = REF_W'(K_MAX);
      end else begin
         k_eff = REF_W'(depth_ff);
      end
      k_idx = KIDX_W'(k_eff - REF_W'(1));
   end

   logic req_acc, rsp_acc;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_acc   = rv_ff && !rsp_stall;
   assign rsp_status          = st_ff;
   assign rsp_evicted_frame   = vic_ff;
   assign rsp_evictable_count = total_ff;

   // scan candidate evaluation on RAM output
   logic               cand, young;
   logic [STAMP_WIDTH-1:0] cstamp;
   logic               take;
   always_comb begin
      cand   = m_rdata.tracked && m_rdata.evictable;
      young  = m_rdata.refs < k_eff;
      cstamp = young ? h_rdata[STAMP_WIDTH-1:0]
                     : h_rdata[k_idx*STAMP_WIDTH +: STAMP_WIDTH];
      priority if (!cand) begin
         take = 1'b0;
      end else if (!best_ok_ff) begin
         take = 1'b1;
      end else if (young && !best_young_ff) begin
         take = 1'b1;
      end else if (young != best_young_ff) begin
         take = 1'b0;
      end else begin
         take = cstamp < best_stamp_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR_WAIT: state_in = S_CLR;
         S_CLR:      if (scan_ff == (FRAME_W+1)'(FRAME_COUNT - 1)) state_in = S_IDLE;
         S_IDLE:     if (req_acc) state_in = S_READ;
         S_READ:     state_in = (act_ff == ACT_EVICT) ? S_SCAN : S_OP;
         S_OP:       state_in = S_RESP;
         S_SCAN:     if (sv_ff && scan_ff == (FRAME_W+1)'(FRAME_COUNT)) state_in = S_VREAD;
         S_VREAD:    state_in = best_ok_ff ? S_VWRITE : S_RESP;
         S_VWRITE:   state_in = S_RESP;
         S_RESP:     if (rsp_acc) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      frames_in = frames_ff;
      depth_in  = depth_ff;
      if (csr_write && csr_index == CSR_FRAMES) frames_in = csr_data;
      if (csr_write && csr_index == CSR_DEPTH)  depth_in  = csr_data[2:0];
      act_in   = act_ff;
      frame_in = frame_ff;
      flag_in  = flag_ff;
      stamp_in = stamp_ff;
      total_in = total_ff;
      scan_in  = scan_ff;
      sv_in    = 1'b0;
      sidx_in  = sidx_ff;
      best_ok_in    = best_ok_ff;
      best_young_in = best_young_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      st_in  = st_ff;
      vic_in = vic_ff;
      rv_in  = rv_ff;
      m_we    = 1'b0;
      m_waddr = frame_ff;
      m_wdata = m_rdata;
      h_we    = 1'b0;
      h_wdata = {h_rdata[HIST_W-STAMP_WIDTH-1:0], stamp_ff};
      m_raddr = frame_ff;
      h_raddr = frame_ff;
      unique case (state_ff)
         S_CLR_WAIT, S_CLR: begin
            m_we    = (state_ff == S_CLR);
            m_waddr = scan_ff[FRAME_W-1:0];
            m_wdata = '0;
            if (state_ff == S_CLR) scan_in = scan_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_acc) begin
               act_in   = req_action;
               frame_in = req_frame;
               flag_in  = req_evictable_flag;
            end
            m_raddr = req_frame;
            h_raddr = req_frame;
            scan_in = '0;
            best_ok_in = 1'b0;
         end
         S_READ: begin
            // RAM outputs valid next cycle; start scan address stream
            if (act_ff == ACT_EVICT) begin
               m_raddr = '0;
               h_raddr = '0;
               scan_in = (FRAME_W+1)'(1);
               sv_in   = 1'b1;
               sidx_in = '0;
            end
         end
         S_OP: begin
            st_in  = ST_OK;
            vic_in = '0;
            rv_in  = 1'b1;
            if ({1'b0, frame_ff} >= limit) begin
               st_in = ST_RANGE;
            end else begin
               unique case (act_ff)
                  ACT_ACCESS: begin
                     m_we = 1'b1;
                     h_we = 1'b1;
                     if (!m_rdata.tracked) begin
                        m_wdata.tracked   = 1'b1;
                        m_wdata.evictable = 1'b0;
                        m_wdata.refs      = REF_W'(1);
                     end else if (m_rdata.refs < REF_W'(K_MAX)) begin
                        m_wdata.refs = m_rdata.refs + 1'b1;
                     end
                     if (!m_rdata.tracked && m_rdata.evictable && total_ff != '0) begin
                        total_in = total_ff - 1'b1;
                     end
                     if (stamp_ff != '1) stamp_in = stamp_ff + 1'b1;
                  end
                  ACT_SET: begin
                     if (!m_rdata.tracked) begin
                        st_in = ST_NOT_TRACKED;
                     end else begin
                        m_we = 1'b1;
                        m_wdata.evictable = flag_ff;
                        if (m_rdata.evictable && !flag_ff && total_ff != '0) begin
                           total_in = total_ff - 1'b1;
                        end else if (!m_rdata.evictable && flag_ff) begin
                           total_in = total_ff + 1'b1;
                        end
                     end
                  end
                  ACT_REMOVE: begin
                     if (m_rdata.tracked) begin
                        if (!m_rdata.evictable) begin
                           st_in = ST_NOT_EVICTABLE;
                        end else begin
                           m_we    = 1'b1;
                           m_wdata = '0;
                           if (total_ff != '0) total_in = total_ff - 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            total_in = (st_in == ST_OK || act_ff != ACT_ACCESS) ? total_in : total_ff;
         end
         S_SCAN: begin
            m_raddr = scan_ff[FRAME_W-1:0];
            h_raddr = scan_ff[FRAME_W-1:0];
            if (scan_ff != (FRAME_W+1)'(FRAME_COUNT)) begin
               scan_in = scan_ff + 1'b1;
               sv_in   = 1'b1;
            end
            if (sv_ff) begin
               sidx_in = sidx_ff + 1'b1;
               if (take) begin
                  best_ok_in    = 1'b1;
                  best_young_in = young;
                  best_in       = sidx_ff;
                  best_stamp_in = cstamp;
               end
            end
         end
         S_VREAD: begin
            m_raddr = best_ff;
            // with a victim the beat waits for the count update in S_VWRITE
            rv_in   = !best_ok_ff;
            st_in   = best_ok_ff ? ST_OK : ST_NONE;
            vic_in  = best_ok_ff ? best_ff : '0;
            frame_in = best_ff;
         end
         S_VWRITE: begin
            m_we    = 1'b1;
            m_waddr = best_ff;
            m_wdata = '0;
            rv_in   = 1'b1;
            if (total_ff != '0) total_in = total_ff - 1'b1;
         end
         S_RESP: begin
            if (rsp_acc) rv_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR_WAIT;
         frames_ff  <= 7'(FRAME_COUNT);
         depth_ff   <= 3'd2;
         stamp_ff   <= '0;
         total_ff   <= '0;
         scan_ff    <= '0;
         sv_ff      <= 1'b0;
         rv_ff      <= 1'b0;
         best_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         frames_ff  <= frames_in;
         depth_ff   <= depth_in;
         stamp_ff   <= stamp_in;
         total_ff   <= total_in;
         scan_ff    <= scan_in;
         sv_ff      <= sv_in;
         rv_ff      <= rv_in;
         best_ok_ff <= best_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      frame_ff      <= frame_in;
      flag_ff       <= flag_in;
      sidx_ff       <= sidx_in;
      best_young_ff <= best_young_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      st_ff         <= st_in;
      vic_ff        <= vic_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COUNT_W'(FRAME_COUNT))
      else $error("evictable count above frame count");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall)
      else $error("request taken while response pending");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && st_ff != ST_OK) |-> vic_ff == '0)
      else $error("victim reported on failure");
endmodule
